>>> sv/clc_pkg.sv
package clc_pkg;

  localparam int KEY_COUNT  = 22;
  localparam int DIR_COUNT  = 17;
  localparam int KEY_CHARS  = 14;
  localparam int CLASS_W    = 5;
  localparam int POS_W      = 5;
  localparam int LEN_W      = 4;

  localparam logic [POS_W-1:0] POS_MAX = 5'd31;

  localparam logic [CLASS_W-1:0] CLS_DRAW    = 5'd0;
  localparam logic [CLASS_W-1:0] CLS_COMMENT = 5'd1;
  localparam logic [CLASS_W-1:0] CLS_NAME    = 5'd18;
  localparam logic [CLASS_W-1:0] CLS_NOP     = 5'd22;
  localparam logic [CLASS_W-1:0] CLS_MOVE    = 5'd23;
  localparam logic [CLASS_W-1:0] CLS_TEXT    = 5'd24;
  localparam logic [CLASS_W-1:0] CLS_UNKNOWN = 5'd25;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_COLON  = 8'h3A;

  localparam logic [8*KEY_CHARS-1:0] KEY_TEXT [KEY_COUNT] = '{
    "$lw", "$color", {"$outline", "_color"}, "$marks", "$noline", {"$scale", "_marks"},
    "$path", {"$mark", "_size"}, {"$text", "_size"}, "$nomark", "$line", "$image",
    "$polygon", {"$marks", "_file"}, {"$low", "_contrast"}, "$title", "$name",
    "title:", "titletext:", "xunittext:", "yunittext:", "largepixels:"
  };

  localparam logic [LEN_W-1:0] KEY_LEN [KEY_COUNT] = '{
    4'd3, 4'd6, 4'd14, 4'd6, 4'd7, 4'd12, 4'd5, 4'd10, 4'd10, 4'd7, 4'd5,
    4'd6, 4'd8, 4'd11, 4'd13, 4'd6, 4'd5,
    4'd6, 4'd10, 4'd10, 4'd10, 4'd12
  };

  localparam logic [CLASS_W-1:0] KEY_CLASS [KEY_COUNT] = '{
    5'd2, 5'd3, 5'd4, 5'd5, 5'd6, 5'd7, 5'd8, 5'd9, 5'd10, 5'd11, 5'd12,
    5'd13, 5'd14, 5'd15, 5'd16, 5'd17, 5'd18,
    5'd17, 5'd17, 5'd19, 5'd20, 5'd21
  };

  typedef struct packed {
    logic               dir_hit;
    logic [CLASS_W-1:0] dir_class;
    logic               lbl_hit;
    logic [CLASS_W-1:0] lbl_class;
  } clc_hit_t;

  function automatic logic [7:0] key_char(input int k, input logic [LEN_W-1:0] pos);
    logic [LEN_W-1:0] idx;
    idx = KEY_LEN[k] - 4'd1 - pos;
    return KEY_TEXT[k][{idx, 3'b000} +: 8];
  endfunction

  function automatic logic [7:0] fold(input logic [7:0] c);
    if (c >= 8'h41 && c <= 8'h5A) begin
      return c + 8'd32;
    end
    return c;
  endfunction

endpackage

>>> sv/clc_match.sv
module clc_match import clc_pkg::*; (
  input  logic [7:0]           ch,
  input  logic [POS_W-1:0]     word_pos,
  input  logic [KEY_COUNT-1:0] alive,
  output logic [KEY_COUNT-1:0] alive_nxt,
  output clc_hit_t             hit
);

  logic [7:0]           ch_fold;
  logic [KEY_COUNT-1:0] full;

  assign ch_fold = fold(ch);

  always_comb begin
    for (int k = 0; k < KEY_COUNT; k++) begin
      if (word_pos >= {1'b0, KEY_LEN[k]}) begin
        alive_nxt[k] = 1'b0;
      end else begin
        alive_nxt[k] = alive[k] && (key_char(k, word_pos[LEN_W-1:0]) == ch_fold);
      end
      full[k] = alive[k] && (word_pos == {1'b0, KEY_LEN[k]});
    end
  end

  // lowest index wins
  always_comb begin
    hit = '0;
    for (int k = DIR_COUNT - 1; k >= 0; k--) begin
      if (full[k]) begin
        hit.dir_hit   = 1'b1;
        hit.dir_class = KEY_CLASS[k];
      end
    end
    for (int k = KEY_COUNT - 1; k >= DIR_COUNT; k--) begin
      if (full[k]) begin
        hit.lbl_hit   = 1'b1;
        hit.lbl_class = KEY_CLASS[k];
      end
    end
  end

endmodule

>>> sv/command_line_classifier.sv
// channel | ports                                              | direction
// in      | in_valid, in_stall, in_ch, in_end_of_line          | word in
// out     | out_valid, out_stall, out_line_class,              | word out
//         | out_unknown_directive, out_unsupported_label       |
//
// One input word per cycle while in_stall is low; a character word updates
// the line state in the cycle it is accepted, an end-of-line word loads the
// result register at the edge that accepts it, so the result shows in the
// next cycle. Character words never produce a result.
// Synchronous active-low reset clears the line state and the result valid.
// in_stall rises only while a result is held by out_stall.
module command_line_classifier import clc_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_ch,
  input  logic               in_end_of_line,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [CLASS_W-1:0] out_line_class,
  output logic               out_unknown_directive,
  output logic               out_unsupported_label
);

  logic [7:0]           lead_r, lead_nxt;
  logic [POS_W-1:0]     pos_r, pos_nxt;
  logic                 open_r, open_nxt;
  logic [KEY_COUNT-1:0] alive_r, alive_nxt, alive_step;
  logic [7:0]           last_r, last_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic [CLASS_W-1:0]   class_r, class_nxt;
  logic                 unk_r, unk_nxt;
  logic                 uns_r, uns_nxt;

  logic                 accept;
  logic                 is_space;
  logic                 lead_letter;
  clc_hit_t             hit;

  clc_match u_match (
    .ch        (in_ch),
    .word_pos  (pos_r),
    .alive     (alive_r),
    .alive_nxt (alive_step),
    .hit       (hit)
  );

  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;
  assign is_space = (in_ch == CH_SPACE) || (in_ch == CH_TAB) || (in_ch == CH_NL);

  assign lead_letter = (lead_r >= 8'h41 && lead_r <= 8'h5A) ||
                       (lead_r >= 8'h61 && lead_r <= 8'h7A);

  always_comb begin
    lead_nxt  = lead_r;
    pos_nxt   = pos_r;
    open_nxt  = open_r;
    alive_nxt = alive_r;
    last_nxt  = last_r;
    if (accept) begin
      if (in_end_of_line) begin
        lead_nxt  = CH_NUL;
        pos_nxt   = '0;
        open_nxt  = 1'b1;
        alive_nxt = '1;
        last_nxt  = CH_NUL;
      end else if (in_ch != CH_NUL) begin
        if (lead_r == CH_NUL) begin
          lead_nxt = in_ch;
        end
        if (open_r) begin
          if (is_space) begin
            if (pos_r != '0) begin
              open_nxt = 1'b0;
            end
          end else begin
            alive_nxt = alive_step;
            last_nxt  = in_ch;
            if (pos_r != POS_MAX) begin
              pos_nxt = pos_r + 5'd1;
            end
          end
        end
      end
    end
  end

  always_comb begin
    class_nxt = CLS_DRAW;
    unk_nxt   = 1'b0;
    uns_nxt   = 1'b0;
    if (lead_r >= 8'h30 && lead_r <= 8'h39) begin
      class_nxt = CLS_DRAW;
    end else if (lead_r == CH_HASH) begin
      class_nxt = CLS_COMMENT;
    end else if (lead_r == CH_DOLLAR) begin
      if (hit.dir_hit) begin
        class_nxt = hit.dir_class;
      end else begin
        class_nxt = CLS_UNKNOWN;
        unk_nxt   = 1'b1;
      end
    end else if (lead_letter && last_r == CH_COLON) begin
      if (hit.lbl_hit) begin
        class_nxt = hit.lbl_class;
      end else begin
        class_nxt = CLS_NOP;
        uns_nxt   = 1'b1;
      end
    end else if (lead_r == 8'h4D || lead_r == 8'h6D) begin
      class_nxt = CLS_MOVE;
    end else if (lead_r == 8'h54 || lead_r == 8'h74) begin
      class_nxt = CLS_TEXT;
    end else if (lead_r == CH_QUOTE) begin
      class_nxt = CLS_NAME;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (accept && in_end_of_line) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lead_r      <= CH_NUL;
      pos_r       <= '0;
      open_r      <= 1'b1;
      alive_r     <= '1;
      last_r      <= CH_NUL;
      out_valid_r <= 1'b0;
    end else begin
      lead_r      <= lead_nxt;
      pos_r       <= pos_nxt;
      open_r      <= open_nxt;
      alive_r     <= alive_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_end_of_line) begin
      class_r <= class_nxt;
      unk_r   <= unk_nxt;
      uns_r   <= uns_nxt;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_line_class        = class_r;
  assign out_unknown_directive = unk_r;
  assign out_unsupported_label = uns_r;

endmodule

>>> sv/clc_checker.sv
module clc_checker import clc_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic [7:0]         in_ch,
  input logic               in_end_of_line,
  input logic               out_valid,
  input logic               out_stall,
  input logic [CLASS_W-1:0] out_line_class,
  input logic               out_unknown_directive,
  input logic               out_unsupported_label
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_line_class))
    else $error("stalled class changed");

  a_eol_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_end_of_line |=> out_valid)
    else $error("end of line gave no result");

  a_unk_class: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_unknown_directive |->
      out_line_class == CLS_UNKNOWN && !out_unsupported_label)
    else $error("unknown directive flag with wrong class");

  a_uns_class: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_unsupported_label |-> out_line_class == CLS_NOP)
    else $error("unsupported label flag with wrong class");

endmodule

bind command_line_classifier clc_checker u_clc_checker (.*);
